/* rtl/assert_macros.svh */
// Assertion helpers shared by the RTL. Each expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CHK_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/bpt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package bpt_pkg;

  // Command codes carried by an input item.
  localparam logic CMD_ACCOUNT = 1'b0;
  localparam logic CMD_RESTART = 1'b1;

  // Configuration register indexes.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_PENALTY_OFFSET    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PENALTY_SCALE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SMOOTH_SHIFT_UP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SMOOTH_SHIFT_DOWN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NICE_INDEX        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SCORE_ENABLE      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_EXCLUDE_KTHREADS  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_TASK_IS_KTHREAD   = 3'd7;

  // Limits of the penalty and the priority range.
  localparam logic [7:0] PENALTY_MAX = 8'd156;
  localparam logic [5:0] PRIO_MAX    = 6'd39;

  // Reset values of the configuration registers.
  localparam logic [6:0]  RST_PENALTY_OFFSET = 7'd24;
  localparam logic [15:0] RST_PENALTY_SCALE  = 16'd1280;
  localparam logic [4:0]  RST_SHIFT_UP       = 5'd1;
  localparam logic [4:0]  RST_SHIFT_DOWN     = 5'd0;
  localparam logic [5:0]  RST_NICE_INDEX     = 6'd20;

  typedef struct packed {
    logic        cmd;
    logic [63:0] run_ns;
  } in_item_t;

  typedef struct packed {
    logic [7:0] penalty_now;
    logic [5:0] score_now;
    logic [5:0] effective_priority;
    logic       priority_changed;
  } out_item_t;

  typedef struct packed {
    logic [6:0]  penalty_offset;
    logic [15:0] penalty_scale;
    logic [4:0]  smooth_shift_up;
    logic [4:0]  smooth_shift_down;
    logic [5:0]  nice_index;
    logic        score_enable;
    logic        exclude_kernel_threads;
    logic        task_is_kernel_thread;
  } cfg_t;

endpackage

`default_nettype wire

/* rtl/burst_penalty_tracker_core.sv */
`timescale 1ns / 1ps
`default_nettype none

// out_valid rises once the item has passed the input, penalty and result
// registers. Throughput: one item per cycle unless out_stall holds the
// pipeline; the penalty state closes its loop in the result stage, so
// back-to-back items need no bubbles.
// Reset (synchronous, rst_n low) clears the pipeline valids and penalty
// state and loads the configuration registers with their defaults.
module burst_penalty_tracker_core (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire bpt_pkg::in_item_t                    in_data,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output bpt_pkg::out_item_t                        out_data,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [bpt_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [bpt_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import bpt_pkg::*;

  cfg_t       cfg_r;
  in_item_t   s1_r;
  logic       v1_r, v2_r, v3_r;
  logic       s2_cmd_r;
  logic [7:0] s2_pen_r;
  logic [7:0] pen_comb;
  logic       adv2, adv3, take_in;
  logic       score_ok;

  // Configuration registers; writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.penalty_offset         <= RST_PENALTY_OFFSET;
      cfg_r.penalty_scale          <= RST_PENALTY_SCALE;
      cfg_r.smooth_shift_up        <= RST_SHIFT_UP;
      cfg_r.smooth_shift_down      <= RST_SHIFT_DOWN;
      cfg_r.nice_index             <= RST_NICE_INDEX;
      cfg_r.score_enable           <= 1'b1;
      cfg_r.exclude_kernel_threads <= 1'b0;
      cfg_r.task_is_kernel_thread  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PENALTY_OFFSET:    cfg_r.penalty_offset         <= cfg_data[6:0];
        REG_PENALTY_SCALE:     cfg_r.penalty_scale          <= cfg_data[15:0];
        REG_SMOOTH_SHIFT_UP:   cfg_r.smooth_shift_up        <= cfg_data[4:0];
        REG_SMOOTH_SHIFT_DOWN: cfg_r.smooth_shift_down      <= cfg_data[4:0];
        REG_NICE_INDEX:        cfg_r.nice_index             <= cfg_data[5:0];
        REG_SCORE_ENABLE:      cfg_r.score_enable           <= cfg_data[0];
        REG_EXCLUDE_KTHREADS:  cfg_r.exclude_kernel_threads <= cfg_data[0];
        REG_TASK_IS_KTHREAD:   cfg_r.task_is_kernel_thread  <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Pipeline advance: a stage moves on when the one after it is free or
  // moving itself.
  assign adv3     = v2_r && (!v3_r || !out_stall);
  assign adv2     = v1_r && (!v2_r || adv3);
  assign in_stall = v1_r && !adv2;
  assign take_in  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (take_in) begin
        v1_r <= 1'b1;
      end else if (adv2) begin
        v1_r <= 1'b0;
      end
      if (adv2) begin
        v2_r <= 1'b1;
      end else if (adv3) begin
        v2_r <= 1'b0;
      end
      if (adv3) begin
        v3_r <= 1'b1;
      end else if (!out_stall) begin
        v3_r <= 1'b0;
      end
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (take_in) begin
      s1_r <= in_data;
    end
  end

  // Penalty stage.
  bpt_penalty u_penalty (
    .run_ns     (s1_r.run_ns),
    .cfg        (cfg_r),
    .penalty    (pen_comb)
  );

  always_ff @(posedge clk) begin
    if (adv2) begin
      s2_cmd_r <= s1_r.cmd;
      s2_pen_r <= pen_comb;
    end
  end

  // State update and result register.
  bpt_update u_update (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (adv3),
    .cmd     (s2_cmd_r),
    .penalty (s2_pen_r),
    .cfg     (cfg_r),
    .result  (out_data)
  );

  assign out_valid = v3_r;

  // The score either follows the penalty or is forced to zero.
  assign score_ok = (out_data.score_now == out_data.penalty_now[7:2]) ||
                    (out_data.score_now == 6'd0);

  `include "assert_macros.svh"

  `CHK_IMPLY(a_pen_max, out_valid, out_data.penalty_now <= PENALTY_MAX, "penalty too high")
  `CHK_IMPLY(a_score, out_valid, score_ok, "score does not follow penalty")
  `CHK_IMPLY(a_prio_max, out_valid, out_data.effective_priority <= PRIO_MAX, "priority high")
  `CHK_NEXT(a_drain, out_valid && !out_stall && !v2_r, !out_valid, "result repeated")

endmodule

`default_nettype wire

/* rtl/bpt_penalty.sv */
`timescale 1ns / 1ps
`default_nettype none

// Turns a burst time into the current penalty: log2 plus one in 7.8 fixed
// point, less the tolerance, scaled and saturated.
module bpt_penalty (
  input  wire logic [63:0]  run_ns,
  input  wire bpt_pkg::cfg_t cfg,
  output logic [7:0]        penalty
);
  import bpt_pkg::*;

  logic [6:0]  msb;
  logic [5:0]  lz;
  logic [63:0] norm;
  logic [7:0]  frac;
  logic [14:0] greed;
  logic [14:0] tol;
  logic [14:0] excess;
  logic [30:0] product;
  logic [14:0] scaled;

  // Priority encoder: bit count up to and including the highest set bit.
  always_comb begin
    msb = 7'd0;
    for (int i = 0; i < 64; i++) begin
      if (run_ns[i]) begin
        msb = 7'(i + 1);
      end
    end
  end

  // Normalise so that the leading one sits at the top, then take the next
  // eight bits as the fraction. A zero burst gives zero in both parts.
  assign lz    = 6'(7'd64 - msb);
  assign norm  = run_ns << lz;
  assign frac  = (msb == 7'd0) ? 8'd0 : norm[62:55];
  assign greed = {msb, frac};

  // Excess above the tolerance, clamped at zero, then scaled.
  assign tol     = {cfg.penalty_offset, 8'd0};
  assign excess  = (greed > tol) ? (greed - tol) : 15'd0;
  assign product = 31'(excess) * 31'(cfg.penalty_scale);
  assign scaled  = product[30:16];

  assign penalty = (scaled > 15'(PENALTY_MAX)) ? PENALTY_MAX : scaled[7:0];

endmodule

`default_nettype wire

/* rtl/bpt_update.sv */
`timescale 1ns / 1ps
`default_nettype none

// Holds the task's penalty state and forms the result register.
module bpt_update (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               load,
  input  wire logic               cmd,
  input  wire logic [7:0]         penalty,
  input  wire bpt_pkg::cfg_t      cfg,
  output bpt_pkg::out_item_t      result
);
  import bpt_pkg::*;

  logic [7:0] prev_r, prev_nxt;
  logic [7:0] cur_r, cur_nxt;
  logic [5:0] score_r, score_nxt;
  logic [7:0] comb;
  logic [7:0] diff;
  logic [5:0] prio_before;
  logic [5:0] prio_after;
  out_item_t  result_r, result_nxt;

  // Effective priority for a given score, capped at the top of the range.
  function automatic logic [5:0] prio_with(input logic [5:0] score, input cfg_t c);
    logic [6:0] sum;
    sum = {1'b0, c.nice_index} + (c.score_enable ? {1'b0, score} : 7'd0);
    return (sum > 7'(PRIO_MAX)) ? PRIO_MAX : sum[5:0];
  endfunction

  // Account takes the new penalty; restart smooths the previous one.
  always_comb begin
    diff     = 8'd0;
    prev_nxt = prev_r;
    cur_nxt  = cur_r;
    comb     = prev_r;
    case (cmd)
      CMD_ACCOUNT: begin
        cur_nxt = penalty;
        comb    = (prev_r > penalty) ? prev_r : penalty;
      end
      CMD_RESTART: begin
        if (cur_r >= prev_r) begin
          diff     = cur_r - prev_r;
          prev_nxt = prev_r + (diff >> cfg.smooth_shift_up);
        end else begin
          diff     = prev_r - cur_r;
          prev_nxt = prev_r - (diff >> cfg.smooth_shift_down);
        end
        cur_nxt = 8'd0;
        comb    = prev_nxt;
      end
      default: begin
        comb = prev_r;
      end
    endcase
  end

  // Score and priority, before and after this transfer.
  always_comb begin
    if (cfg.task_is_kernel_thread && cfg.exclude_kernel_threads) begin
      score_nxt = 6'd0;
    end else begin
      score_nxt = comb[7:2];
    end
    prio_before = prio_with(score_r, cfg);
    prio_after  = prio_with(score_nxt, cfg);
    result_nxt.penalty_now        = comb;
    result_nxt.score_now          = score_nxt;
    result_nxt.effective_priority = prio_after;
    result_nxt.priority_changed   = (prio_after != prio_before);
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r  <= 8'd0;
      cur_r   <= 8'd0;
      score_r <= 6'd0;
    end else if (load) begin
      prev_r  <= prev_nxt;
      cur_r   <= cur_nxt;
      score_r <= score_nxt;
    end
  end

  // Result register, payload only.
  always_ff @(posedge clk) begin
    if (load) begin
      result_r <= result_nxt;
    end
  end

  assign result = result_r;

endmodule

`default_nettype wire
